// ===== rtl/swm_pkg.sv =====
// Shared types and constants for the suitor weighted matching block.
// Used by swm_core and suitor_weighted_matching; no dependencies.
package swm_pkg;

    localparam int NODE_BITS   = 10;
    localparam int PORT_W_BITS = 32;
    localparam int SUM_BITS    = 42;
    localparam int CFG_BITS    = 11;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;
    localparam logic KIND_RUN   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_Q_RD,
        S_Q_OUT,
        S_SET_RD,
        S_SET_WR,
        S_ROW_A,
        S_ROW_B,
        S_ROW_C,
        S_SC_ADJ,
        S_SC_SUI,
        S_SC_CMP,
        S_UPD_RD,
        S_UPD_WR,
        S_NEXT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                   kind;
        logic [NODE_BITS-1:0]   mate;
        logic [PORT_W_BITS-1:0] mate_weight;
        logic                   has_mate;
        logic [SUM_BITS-1:0]    sum;
        logic                   dropped;
    } t_res;

endpackage

// ===== rtl/swm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module swm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/swm_core.sv =====
// Sequencer and shared compare/update datapath of the suitor matching block.
// Depends on swm_pkg and swm_ram (row ends, adjacency list, suitor table).
module swm_core #(
    parameter int MAX_NODES   = 1024,
    parameter int MAX_ENTRIES = 8192,
    parameter int WEIGHT_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_mode,
    input  logic [swm_pkg::NODE_BITS-1:0]     i_owner_node,
    input  logic [swm_pkg::NODE_BITS-1:0]     i_neighbour_node,
    input  logic [swm_pkg::PORT_W_BITS-1:0]   i_edge_weight,
    input  logic                              i_last_entry,
    input  logic [swm_pkg::NODE_BITS-1:0]     i_query_node,
    input  logic [swm_pkg::CFG_BITS-1:0]      i_node_count,
    output logic                              o_res_valid,
    output swm_pkg::t_res                     o_res,
    input  logic                              i_res_ready
);
    import swm_pkg::*;

    localparam int NW = $clog2(MAX_NODES);
    localparam int UW = NW + 1;
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int EW = $clog2(MAX_ENTRIES + 1);
    localparam int WB = WEIGHT_BITS;
    localparam int ROW_W = 1 + EW;
    localparam int ADJ_W = NODE_BITS + WB;
    localparam int SUI_W = 1 + NW + WB;

    t_state r_state, n_state;
    logic [UW-1:0]        r_u, n_u;
    logic [UW-1:0]        r_limit, n_limit;
    logic [EW-1:0]        r_run, n_run;
    logic [NW-1:0]        r_cur, n_cur;
    logic [EW-1:0]        r_i, n_i;
    logic [EW-1:0]        r_last, n_last;
    logic [NW-1:0]        r_best, n_best;
    logic [WB-1:0]        r_heavy, n_heavy;
    logic [NODE_BITS-1:0] r_v, n_v;
    logic [WB-1:0]        r_w, n_w;
    logic [SUM_BITS-1:0]  r_sum, n_sum;
    logic [EW-1:0]        r_cnt, n_cnt;
    logic                 r_ovf, n_ovf;
    logic                 r_qok, n_qok;

    logic             row_we, adj_we, sui_we;
    logic [NW-1:0]    row_waddr, row_raddr, sui_waddr, sui_raddr;
    logic [ROW_W-1:0] row_wdata, row_rdata;
    logic [AW-1:0]    adj_waddr, adj_raddr;
    logic [ADJ_W-1:0] adj_wdata, adj_rdata;
    logic [SUI_W-1:0] sui_wdata, sui_rdata;

    logic          row_wr_bit;
    logic [EW-1:0] row_end, settled;
    logic          sui_valid;
    logic [NW-1:0] sui_node;
    logic [WB-1:0] sui_weight;
    logic          entry_ok, v_ok;

    assign row_wr_bit = row_rdata[ROW_W-1];
    assign row_end    = row_rdata[EW-1:0];
    assign sui_valid  = sui_rdata[SUI_W-1];
    assign sui_node   = sui_rdata[NW+WB-1:WB];
    assign sui_weight = sui_rdata[WB-1:0];
    assign settled    = (row_wr_bit && row_end > r_run) ? row_end : r_run;
    assign entry_ok   = (32'(i_owner_node) < MAX_NODES) && (r_cnt < EW'(MAX_ENTRIES));
    assign v_ok       = 32'(r_v) < MAX_NODES;

    swm_ram #(.WIDTH(ROW_W), .DEPTH(MAX_NODES)) u_row (
        .i_clk(i_clk), .i_we(row_we), .i_waddr(row_waddr), .i_wdata(row_wdata),
        .i_raddr(row_raddr), .o_rdata(row_rdata)
    );
    swm_ram #(.WIDTH(ADJ_W), .DEPTH(MAX_ENTRIES)) u_adj (
        .i_clk(i_clk), .i_we(adj_we), .i_waddr(adj_waddr), .i_wdata(adj_wdata),
        .i_raddr(adj_raddr), .o_rdata(adj_rdata)
    );
    swm_ram #(.WIDTH(SUI_W), .DEPTH(MAX_NODES)) u_sui (
        .i_clk(i_clk), .i_we(sui_we), .i_waddr(sui_waddr), .i_wdata(sui_wdata),
        .i_raddr(sui_raddr), .o_rdata(sui_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_u     <= '0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_u     <= n_u;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_limit <= n_limit;
        r_run   <= n_run;
        r_cur   <= n_cur;
        r_i     <= n_i;
        r_last  <= n_last;
        r_best  <= n_best;
        r_heavy <= n_heavy;
        r_v     <= n_v;
        r_w     <= n_w;
        r_sum   <= n_sum;
        r_qok   <= n_qok;
    end

    always_comb begin
        n_state = r_state;
        n_u     = r_u;
        n_limit = r_limit;
        n_run   = r_run;
        n_cur   = r_cur;
        n_i     = r_i;
        n_last  = r_last;
        n_best  = r_best;
        n_heavy = r_heavy;
        n_v     = r_v;
        n_w     = r_w;
        n_sum   = r_sum;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        n_qok   = r_qok;

        o_ready     = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;

        row_we    = 1'b0;
        row_waddr = r_u[NW-1:0];
        row_wdata = '0;
        row_raddr = r_cur;
        adj_we    = 1'b0;
        adj_waddr = r_cnt[AW-1:0];
        adj_wdata = {i_neighbour_node, WB'(i_edge_weight)};
        adj_raddr = r_i[AW-1:0];
        sui_we    = 1'b0;
        sui_waddr = r_u[NW-1:0];
        sui_wdata = '0;
        sui_raddr = r_best;

        case (r_state)
            S_INIT: begin
                row_we = 1'b1;
                sui_we = 1'b1;
                n_u    = r_u + 1'b1;
                if (r_u == UW'(MAX_NODES - 1)) begin
                    n_u     = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_mode == MODE_QUERY) begin
                        n_qok   = 32'(i_query_node) < MAX_NODES;
                        n_cur   = NW'(i_query_node);
                        n_state = S_Q_RD;
                    end else begin
                        if (entry_ok) begin
                            adj_we    = 1'b1;
                            row_we    = 1'b1;
                            row_waddr = NW'(i_owner_node);
                            row_wdata = {1'b1, r_cnt + 1'b1};
                            n_cnt     = r_cnt + 1'b1;
                        end else begin
                            n_ovf = 1'b1;
                        end
                        if (i_last_entry) begin
                            n_u     = '0;
                            n_run   = '0;
                            n_state = S_SET_RD;
                        end
                    end
                end
            end
            S_Q_RD: begin
                sui_raddr = r_cur;
                n_state   = S_Q_OUT;
            end
            S_Q_OUT: begin
                sui_raddr   = r_cur;
                o_res_valid = 1'b1;
                o_res.kind  = KIND_QUERY;
                if (r_qok && sui_valid) begin
                    o_res.has_mate    = 1'b1;
                    o_res.mate        = NODE_BITS'(sui_node);
                    o_res.mate_weight = PORT_W_BITS'(sui_weight);
                end
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_SET_RD: begin
                row_raddr = r_u[NW-1:0];
                n_state   = S_SET_WR;
            end
            S_SET_WR: begin
                row_we    = 1'b1;
                row_wdata = {1'b0, settled};
                sui_we    = 1'b1;
                n_run     = settled;
                n_u       = r_u + 1'b1;
                n_state   = S_SET_RD;
                if (r_u == UW'(MAX_NODES - 1)) begin
                    n_u     = '0;
                    n_sum   = '0;
                    n_heavy = '0;
                    n_cur   = '0;
                    n_limit = (32'(i_node_count) > MAX_NODES) ? UW'(MAX_NODES)
                                                             : UW'(i_node_count);
                    n_state = (i_node_count == '0) ? S_DONE : S_ROW_A;
                end
            end
            S_ROW_A: begin
                row_raddr = r_cur - 1'b1;
                n_state   = S_ROW_B;
            end
            S_ROW_B: begin
                row_raddr = r_cur;
                n_i       = (r_cur == '0) ? '0 : row_end;
                n_state   = S_ROW_C;
            end
            S_ROW_C: begin
                n_last  = row_end;
                n_state = S_SC_ADJ;
            end
            S_SC_ADJ: begin
                if (r_i < r_last) begin
                    n_state = S_SC_SUI;
                end else if (r_heavy == '0) begin
                    n_state = S_NEXT;
                end else begin
                    n_state = S_UPD_RD;
                end
            end
            S_SC_SUI: begin
                n_v       = adj_rdata[ADJ_W-1:WB];
                n_w       = adj_rdata[WB-1:0];
                sui_raddr = NW'(adj_rdata[ADJ_W-1:WB]);
                n_state   = S_SC_CMP;
            end
            S_SC_CMP: begin
                if (v_ok && r_w > r_heavy && r_w > sui_weight) begin
                    n_best  = NW'(r_v);
                    n_heavy = r_w;
                end
                n_i     = r_i + 1'b1;
                n_state = S_SC_ADJ;
            end
            S_UPD_RD: begin
                n_state = S_UPD_WR;
            end
            S_UPD_WR: begin
                sui_we    = 1'b1;
                sui_waddr = r_best;
                sui_wdata = {1'b1, r_cur, r_heavy};
                n_sum     = r_sum + SUM_BITS'(r_heavy) - SUM_BITS'(sui_weight);
                n_heavy   = '0;
                if (sui_valid) begin
                    n_cur   = sui_node;
                    n_state = S_ROW_A;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                n_u     = r_u + 1'b1;
                n_heavy = '0;
                n_cur   = NW'(r_u + 1'b1);
                n_state = (r_u + 1'b1 == r_limit) ? S_DONE : S_ROW_A;
            end
            S_DONE: begin
                o_res_valid   = 1'b1;
                o_res.kind    = KIND_RUN;
                o_res.sum     = r_sum;
                o_res.dropped = r_ovf;
                if (i_res_ready) begin
                    n_cnt   = '0;
                    n_ovf   = 1'b0;
                    n_u     = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end
endmodule

// ===== rtl/suitor_weighted_matching.sv =====
// Suitor half-approximate weighted matching: top level, config register, output register.
// Order: a load entry is written while idle; a query reads its suitor slot, then answers;
// a run settles the row ends of all MAX_NODES nodes, then per visit reads the row bounds
// and scans each adjacency entry, takes a suitor slot and advances; results are registered.
// Throughput: one request at a time; loads may follow every cycle.
// Reset: synchronous, active low; then the row-end and suitor tables are cleared, not ready.
module suitor_weighted_matching #(
    parameter int MAX_NODES   = 1024,
    parameter int MAX_ENTRIES = 8192,
    parameter int WEIGHT_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [swm_pkg::CFG_BITS-1:0]      i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_mode,
    input  logic [swm_pkg::NODE_BITS-1:0]     i_owner_node,
    input  logic [swm_pkg::NODE_BITS-1:0]     i_neighbour_node,
    input  logic [swm_pkg::PORT_W_BITS-1:0]   i_edge_weight,
    input  logic                              i_last_entry,
    input  logic [swm_pkg::NODE_BITS-1:0]     i_query_node,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_result_kind,
    output logic [swm_pkg::NODE_BITS-1:0]     o_mate_node,
    output logic [swm_pkg::PORT_W_BITS-1:0]   o_mate_weight,
    output logic                              o_has_mate,
    output logic [swm_pkg::SUM_BITS-1:0]      o_weight_sum,
    output logic                              o_entries_dropped
);
    import swm_pkg::*;

    logic [CFG_BITS-1:0] r_node_count;
    logic                r_out_valid;
    t_res                r_out;
    t_res                core_res;
    logic                core_res_valid, core_res_ready;

    assign core_res_ready = !r_out_valid || i_out_ready;

    swm_core #(
        .MAX_NODES(MAX_NODES), .MAX_ENTRIES(MAX_ENTRIES), .WEIGHT_BITS(WEIGHT_BITS)
    ) u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_in_valid), .o_ready(o_in_ready),
        .i_mode(i_mode), .i_owner_node(i_owner_node),
        .i_neighbour_node(i_neighbour_node), .i_edge_weight(i_edge_weight),
        .i_last_entry(i_last_entry), .i_query_node(i_query_node),
        .i_node_count(r_node_count),
        .o_res_valid(core_res_valid), .o_res(core_res), .i_res_ready(core_res_ready)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= CFG_BITS'(1024);
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_data;
            end
            if (core_res_ready) begin
                r_out_valid <= core_res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_res_ready && core_res_valid) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_result_kind     = r_out.kind;
    assign o_mate_node       = r_out.mate;
    assign o_mate_weight     = r_out.mate_weight;
    assign o_has_mate        = r_out.has_mate;
    assign o_weight_sum      = r_out.sum;
    assign o_entries_dropped = r_out.dropped;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
    a_no_mate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_mate |-> o_mate_weight == '0 && o_mate_node == '0)
        else $error("mate fields set without a mate");
    a_run_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == KIND_RUN |-> !o_has_mate)
        else $error("run result carries a mate");
    a_query_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == KIND_QUERY |-> o_weight_sum == '0 && !o_entries_dropped)
        else $error("query result carries run fields");
endmodule
